@@ src/pwnt_pkg.sv @@
// Shared types, constants and codes for the preference weighted neighbour test.
`default_nettype none

package pwnt_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_DIMS_DEF = 64;
  localparam int SPREAD_W     = 32;
  localparam int WEIGHT_W     = 16;
  localparam int ACC_W        = 56;
  localparam int MODE_W       = 2;
  localparam int CNT_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int SQ_W         = 2 * COORD_BITS;
  localparam int PROD_W       = WEIGHT_W + SQ_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
  localparam logic [WEIGHT_W-1:0] KAPPA_RST  = WEIGHT_W'(256);

  // metric modes; the unused code behaves as euclidean squared
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EUCL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KAPPA   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_p;
    logic signed [COORD_BITS-1:0] coord_q;
    logic [SPREAD_W-1:0]          spread_p;
    logic [SPREAD_W-1:0]          spread_q;
    logic                         final_dim;
  } pwnt_in_t;

  typedef struct packed {
    logic             is_neighbour;
    logic [ACC_W-1:0] pair_measure;
    logic [CNT_W-1:0] narrow_dims_p;
    logic [CNT_W-1:0] narrow_dims_q;
  } pwnt_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic mul;
    logic acc;
    logic emit;
  } pwnt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } pwnt_stat_t;

endpackage

`default_nettype wire

@@ src/preference_weighted_neighbour_test.sv @@
// Top level: preference weighted neighbour test for one pair of points.
//
// Usage: a pair of points streams in one dimension per request on the input
// channel (in_valid_i / in_stall_o), carrying both coordinates, both
// variances and final_dim. After the request with final_dim set, one result
// request leaves on the output channel (out_valid_o / out_stall_i) with the
// larger weighted distance, the epsilon flag and both narrow counts.
// Timing: each dimension passes through load, difference, square, weight
// multiply and accumulate steps, and the input stalls until it is through,
// so a new request is taken only once the last one is done; the final
// dimension adds a result step that writes the output register. The two
// multiplies in series, each registered, are the square and multiply steps.
// The output register holds one result; a new pair may stream in while it
// waits. If the receiver stalls and a second result is ready, the block
// holds in its result step and stalls the input until the register frees.
// Reset clears the accumulators and counts, empties the output register and
// loads epsilon 0, delta 0, kappa 1.0 and the euclidean squared mode.
// Configuration writes are always accepted; write only while idle.
`default_nettype none

module preference_weighted_neighbour_test #(
  parameter int MAX_DIMS = pwnt_pkg::MAX_DIMS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // dimension requests
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire pwnt_pkg::pwnt_in_t             in_req_i,
  // result requests
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output pwnt_pkg::pwnt_out_t                 out_data_o,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pwnt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pwnt_pkg::ACC_W-1:0]     cfg_data_i
);

  pwnt_pkg::pwnt_cmd_t  cmd;
  pwnt_pkg::pwnt_stat_t stat;

  // registers are plain flops that can always take a write
  assign cfg_ready_o = 1'b1;

  pwnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pwnt_dp #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/pwnt_ctrl.sv @@
// Sequencing state machine for one dimension request and the pair result.
`default_nettype none

module pwnt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pwnt_pkg::pwnt_stat_t stat_i,
  output pwnt_pkg::pwnt_cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // wait for room in the output register
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pwnt_dp.sv @@
// Datapath: config registers, weighting, products, accumulators, output register.
`default_nettype none

module pwnt_dp #(
  parameter int MAX_DIMS = pwnt_pkg::MAX_DIMS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pwnt_pkg::pwnt_in_t                 in_req_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [pwnt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pwnt_pkg::ACC_W-1:0]         cfg_data_i,
  input  wire pwnt_pkg::pwnt_cmd_t                cmd_i,
  output pwnt_pkg::pwnt_stat_t                    stat_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output pwnt_pkg::pwnt_out_t                     out_data_o
);

  localparam int CW       = pwnt_pkg::COORD_BITS;
  localparam int AW       = pwnt_pkg::ACC_W;
  localparam int CAP_INT  = (MAX_DIMS < 127) ? MAX_DIMS : 127;
  localparam logic [pwnt_pkg::CNT_W-1:0] CNT_CAP = pwnt_pkg::CNT_W'(CAP_INT);

  // config registers
  logic [AW-1:0]                  eps_q;
  logic [pwnt_pkg::SPREAD_W-1:0]  delta_q;
  logic [pwnt_pkg::WEIGHT_W-1:0]  kappa_q;
  logic [pwnt_pkg::MODE_W-1:0]    mode_q;

  // per-dimension pipeline registers
  pwnt_pkg::pwnt_in_t             req_q;
  logic [CW-1:0]                  dist_q, dist_d;
  logic [pwnt_pkg::WEIGHT_W-1:0]  wp_q, wq_q, wp_d, wq_d;
  logic [pwnt_pkg::SQ_W-1:0]      term_q, term_d;
  logic [pwnt_pkg::PROD_W-1:0]    prod_p_q, prod_q_q;

  // pair state
  logic [AW-1:0]                  sum_p_q, sum_q_q, sum_p_d, sum_q_d;
  logic [pwnt_pkg::CNT_W-1:0]     cnt_p_q, cnt_q_q, cnt_p_d, cnt_q_d;

  logic                           out_valid_q, out_valid_d;
  pwnt_pkg::pwnt_out_t            out_q, out_d;

  logic [CW:0]                    diff, mag;
  logic                           narrow_p, narrow_q;
  logic [AW-1:0]                  measure;

  function automatic logic [AW-1:0] accumulate(
    input logic [AW-1:0]                   acc,
    input logic [pwnt_pkg::PROD_W-1:0]     prod,
    input logic [pwnt_pkg::MODE_W-1:0]     mode
  );
    logic [AW-1:0] term;
    logic [AW:0]   total;
    term  = AW'(prod);
    total = {1'b0, acc} + {1'b0, term};
    case (mode)
      pwnt_pkg::MODE_MAX: accumulate = (term > acc) ? term : acc;
      default:            accumulate = total[AW] ? {AW{1'b1}} : total[AW-1:0];
    endcase
  endfunction

  // absolute coordinate difference, weights and narrow flags
  always_comb begin
    diff     = {req_q.coord_p[CW-1], req_q.coord_p} - {req_q.coord_q[CW-1], req_q.coord_q};
    mag      = diff[CW] ? (~diff + 1'b1) : diff;
    dist_d   = mag[CW-1:0];
    narrow_p = (req_q.spread_p <= delta_q);
    narrow_q = (req_q.spread_q <= delta_q);
    wp_d     = narrow_p ? kappa_q : pwnt_pkg::WEIGHT_ONE;
    wq_d     = narrow_q ? kappa_q : pwnt_pkg::WEIGHT_ONE;
  end

  // distance or its square, depending on the mode
  always_comb begin
    if (mode_q == pwnt_pkg::MODE_MAX || mode_q == pwnt_pkg::MODE_MANH) begin
      term_d = pwnt_pkg::SQ_W'(dist_q);
    end else begin
      term_d = dist_q * dist_q;
    end
  end

  always_comb begin
    sum_p_d = sum_p_q;
    sum_q_d = sum_q_q;
    cnt_p_d = cnt_p_q;
    cnt_q_d = cnt_q_q;
    if (cmd_i.diff) begin
      if (narrow_p && cnt_p_q < CNT_CAP) begin
        cnt_p_d = pwnt_pkg::CNT_W'(cnt_p_q + 1'b1);
      end
      if (narrow_q && cnt_q_q < CNT_CAP) begin
        cnt_q_d = pwnt_pkg::CNT_W'(cnt_q_q + 1'b1);
      end
    end
    if (cmd_i.acc) begin
      sum_p_d = accumulate(sum_p_q, prod_p_q, mode_q);
      sum_q_d = accumulate(sum_q_q, prod_q_q, mode_q);
    end
    if (cmd_i.emit) begin
      sum_p_d = '0;
      sum_q_d = '0;
      cnt_p_d = '0;
      cnt_q_d = '0;
    end
  end

  // result and output register
  always_comb begin
    measure            = (sum_p_q > sum_q_q) ? sum_p_q : sum_q_q;
    out_d.is_neighbour = (measure <= eps_q);
    out_d.pair_measure = measure;
    out_d.narrow_dims_p = cnt_p_q;
    out_d.narrow_dims_q = cnt_q_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign stat_o.last     = req_q.final_dim;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= '0;
      delta_q <= '0;
      kappa_q <= pwnt_pkg::KAPPA_RST;
      mode_q  <= pwnt_pkg::MODE_EUCL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwnt_pkg::REG_EPSILON: eps_q   <= cfg_data_i;
        pwnt_pkg::REG_DELTA:   delta_q <= cfg_data_i[pwnt_pkg::SPREAD_W-1:0];
        pwnt_pkg::REG_KAPPA:   kappa_q <= cfg_data_i[pwnt_pkg::WEIGHT_W-1:0];
        pwnt_pkg::REG_MODE:    mode_q  <= cfg_data_i[pwnt_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // control and pair state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_p_q     <= '0;
      sum_q_q     <= '0;
      cnt_p_q     <= '0;
      cnt_q_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_p_q     <= sum_p_d;
      sum_q_q     <= sum_q_d;
      cnt_p_q     <= cnt_p_d;
      cnt_q_q     <= cnt_q_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.diff) begin
      dist_q <= dist_d;
      wp_q   <= wp_d;
      wq_q   <= wq_d;
    end
    if (cmd_i.square) begin
      term_q <= term_d;
    end
    if (cmd_i.mul) begin
      prod_p_q <= wp_q * term_q;
      prod_q_q <= wq_q * term_q;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/neighbour_verdict_pkg.sv @@
`timescale 1ns / 1ps
// Pair verdict predictor and result checker for the preference weighted neighbour test.
package neighbour_verdict_pkg;
  import pwnt_pkg::*;

  // spare metric code, behaves as euclidean squared
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [63:0]       ACC_LIMIT  = (64'd1 << ACC_W) - 64'd1;
  localparam int                NARROW_CAP = (MAX_DIMS_DEF < 127) ? MAX_DIMS_DEF : 127;

  class pair_verdict_board;
    logic [ACC_W-1:0]    eps_reg;
    logic [SPREAD_W-1:0] delta_reg;
    logic [WEIGHT_W-1:0] kappa_reg;
    logic [MODE_W-1:0]   metric_reg;
    logic [63:0]         dist_sum_p;
    logic [63:0]         dist_sum_q;
    int                  narrow_p;
    int                  narrow_q;
    pwnt_out_t           pending_verdicts[$];
    int                  mismatches;

    function new();
      eps_reg    = '0;
      delta_reg  = '0;
      kappa_reg  = KAPPA_RST;
      metric_reg = MODE_EUCL;
      dist_sum_p = '0;
      dist_sum_q = '0;
      narrow_p   = 0;
      narrow_q   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ACC_W-1:0] value);
      case (idx)
        REG_EPSILON: eps_reg = value;
        REG_DELTA:   delta_reg = value[SPREAD_W-1:0];
        REG_KAPPA:   kappa_reg = value[WEIGHT_W-1:0];
        REG_MODE:    metric_reg = value[MODE_W-1:0];
        default:     ;
      endcase
    endfunction

    // w*d*d stays below 2^48, so only the running sum needs clamping
    function logic [63:0] grow(logic [63:0] acc, logic [WEIGHT_W-1:0] w, logic [63:0] span);
      logic [63:0] term;
      logic [63:0] total;
      if (metric_reg == MODE_MAX) begin
        term = 64'(w) * span;
        return (term > acc) ? term : acc;
      end
      if (metric_reg == MODE_MANH) term = 64'(w) * span;
      else term = 64'(w) * span * span;
      total = acc + term;
      return (total > ACC_LIMIT) ? ACC_LIMIT : total;
    endfunction

    function void take_dimension(pwnt_in_t dim);
      longint              gap;
      logic [63:0]         span;
      logic [63:0]         wide;
      logic [WEIGHT_W-1:0] w_p;
      logic [WEIGHT_W-1:0] w_q;
      pwnt_out_t           verdict;
      gap  = longint'($signed(dim.coord_p)) - longint'($signed(dim.coord_q));
      span = (gap < 0) ? -gap : gap;
      w_p  = WEIGHT_ONE;
      w_q  = WEIGHT_ONE;
      if (dim.spread_p <= delta_reg) begin
        w_p = kappa_reg;
        if (narrow_p < NARROW_CAP) narrow_p++;
      end
      if (dim.spread_q <= delta_reg) begin
        w_q = kappa_reg;
        if (narrow_q < NARROW_CAP) narrow_q++;
      end
      dist_sum_p = grow(dist_sum_p, w_p, span);
      dist_sum_q = grow(dist_sum_q, w_q, span);
      if (!dim.final_dim) return;
      wide = (dist_sum_p > dist_sum_q) ? dist_sum_p : dist_sum_q;
      verdict.is_neighbour  = (wide <= 64'(eps_reg));
      verdict.pair_measure  = wide[ACC_W-1:0];
      verdict.narrow_dims_p = CNT_W'(narrow_p);
      verdict.narrow_dims_q = CNT_W'(narrow_q);
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      dist_sum_p = '0;
      dist_sum_q = '0;
      narrow_p   = 0;
      narrow_q   = 0;
    endfunction

    function void flag_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void compare_verdict(pwnt_out_t got);
      pwnt_out_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with no pending verdict, pair_measure %0d", got.pair_measure);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      flag_field("is_neighbour", 64'(want.is_neighbour), 64'(got.is_neighbour));
      flag_field("pair_measure", 64'(want.pair_measure), 64'(got.pair_measure));
      flag_field("narrow_dims_p", 64'(want.narrow_dims_p), 64'(got.narrow_dims_p));
      flag_field("narrow_dims_q", 64'(want.narrow_dims_q), 64'(got.narrow_dims_q));
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Stimulus, result monitor and watchdog for the preference weighted neighbour test.
module tb_top;
  import pwnt_pkg::*;
  import neighbour_verdict_pkg::*;

  localparam int STALL_LIMIT   = 2000; // cycles without any accepted request
  localparam int LONG_HOLD     = 80;   // long receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 12;   // a non-final dimension can still be in flight
  localparam int SAT_DIMS      = 270;  // enough max-size terms to pass 2^56-1

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  pwnt_in_t             in_req;
  logic                 out_valid;
  logic                 out_stall;
  pwnt_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ACC_W-1:0]     cfg_data;

  bit                   quiet;        // no idling on either side
  bit                   hold_request; // asks the sink for one long hold-off
  int                   idle_cycles;
  pair_verdict_board    verdicts;

  logic [MODE_W-1:0] metric_list [4] = '{MODE_MAX, MODE_MANH, MODE_EUCL, MODE_SPARE};
  logic [WEIGHT_W-1:0] kappa_list [4] = '{16'd256, 16'd0, 16'hFFFF, 16'd384};

  preference_weighted_neighbour_test DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // ------------------------------------------------------------------
  // Result sink: stall decided at the falling edge, so the value seen
  // at the rising edge is settled. Short random bursts of stall, plus
  // one long hold-off counted here when the stimulus asks for it.
  // ------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 3);
        out_stall  = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor and watchdog, both on the rising edge. A result request is
  // checked against the oldest pending verdict. The watchdog only counts
  // cycles in which no channel moves anything.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) verdicts.compare_verdict(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic pwnt_in_t make_dim(input logic [COORD_BITS-1:0] cp,
                                        input logic [COORD_BITS-1:0] cq,
                                        input logic [SPREAD_W-1:0] sp,
                                        input logic [SPREAD_W-1:0] sq,
                                        input logic fin);
    pwnt_in_t d;
    d.coord_p   = cp;
    d.coord_q   = cq;
    d.spread_p  = sp;
    d.spread_q  = sq;
    d.final_dim = fin;
    return d;
  endfunction

  // log-uniform over the whole accumulator range
  function automatic logic [ACC_W-1:0] rand_acc();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return ACC_W'(raw >> (64 - ACC_W + $urandom_range(0, ACC_W - 1)));
  endfunction

  // variances cluster around delta so the boundary of the compare is hit often
  function automatic logic [SPREAD_W-1:0] rand_spread();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2, 3:    return verdicts.delta_reg + SPREAD_W'($urandom_range(0, 4)) - SPREAD_W'(2);
      default: return SPREAD_W'($urandom);
    endcase
  endfunction

  function automatic pwnt_in_t rand_dim(input logic fin);
    pwnt_in_t d;
    logic [COORD_BITS-1:0] base;
    base    = COORD_BITS'($urandom);
    d.coord_p = base;
    case ($urandom_range(0, 3))
      0: d.coord_q = base + COORD_BITS'($urandom_range(0, 512)) - COORD_BITS'(256);
      1: begin
        d.coord_p = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        d.coord_q = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      default: d.coord_q = COORD_BITS'($urandom);
    endcase
    d.spread_p  = rand_spread();
    d.spread_q  = rand_spread();
    d.final_dim = fin;
    return d;
  endfunction

  function automatic logic [ACC_W-1:0] pick_eps();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return rand_acc();
    endcase
  endfunction

  function automatic logic [SPREAD_W-1:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return SPREAD_W'($urandom);
    endcase
  endfunction

  // Offer one dimension request; entered and left at a falling edge.
  task automatic send_dim(input pwnt_in_t dim);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_req   = dim;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    verdicts.take_dimension(dim);
    @(negedge clk);
  endtask

  // Pairs of 1..8 dimensions; optionally leave a pair open so the next
  // configuration lands in the middle of it.
  task automatic random_pairs(input int items, input bit leave_open);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) send_dim(rand_dim(k == len - 1));
      sent += len;
    end
    if (leave_open) repeat ($urandom_range(1, 3)) send_dim(rand_dim(1'b0));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    verdicts.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Sender pauses until every pending verdict is in, then lets a possible
  // non-final dimension leave the pipeline.
  task automatic drain();
    in_valid = 1'b0;
    while (verdicts.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] metric, input logic [ACC_W-1:0] eps,
                           input logic [SPREAD_W-1:0] delta, input logic [WEIGHT_W-1:0] kappa);
    drain();
    write_reg(REG_EPSILON, eps);
    write_reg(REG_DELTA, ACC_W'(delta));
    write_reg(REG_KAPPA, ACC_W'(kappa));
    write_reg(REG_MODE, ACC_W'(metric));
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_EPSILON;
    cfg_data     = '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    idle_cycles  = 0;
    verdicts     = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed, reset settings: eps 0, delta 0, kappa 1.0, euclidean ---
    // identical coordinates: zero distance is a neighbour even at eps 0;
    // spreads of 0 are not above delta, so both count narrow at weight one
    send_dim(make_dim(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b1));
    // widest gap, both wide
    send_dim(make_dim(16'h7FFF, 16'h8000, '1, '1, 1'b1));
    // two dimensions, p and q narrow in different ones (kappa 1.0 keeps weights equal)
    send_dim(make_dim(16'h8000, 16'h7FFF, 32'h0, '1, 1'b0));
    send_dim(make_dim(16'h7FFF, 16'h8000, '1, 32'h0, 1'b1));
    // spread just above delta
    send_dim(make_dim(16'h0100, 16'hFF00, 32'h1, 32'h0, 1'b0));
    send_dim(make_dim(16'hFF00, 16'h0100, 32'h0, 32'h1, 1'b1));

    // --- directed, every metric code including the spare one ---
    for (int m = 0; m < 4; m++) begin
      configure(metric_list[m], pick_eps(), 32'h8000_0000, kappa_list[m]);
      // spread equal to delta is narrow, one above is wide
      send_dim(make_dim(16'h0180, 16'hFE80, 32'h8000_0000, 32'h8000_0001, 1'b0));
      send_dim(make_dim(16'h8000, 16'h7FFF, 32'h8000_0001, 32'h8000_0000, 1'b0));
      send_dim(make_dim(16'h1234, 16'h1234, 32'hFFFF_FFFF, 32'h0, 1'b1));
    end

    // --- random phases, cycling through the metric codes ---
    for (int phase = 0; phase < 8; phase++) begin
      configure(metric_list[phase % 4], pick_eps(), pick_delta(),
                ($urandom_range(0, 1) != 0) ? kappa_list[$urandom_range(0, 3)]
                                            : WEIGHT_W'($urandom));
      if (phase == 3) begin
        // sink holds off long; single-dimension pairs keep coming so the
        // result register fills and the input side backs up
        hold_request = 1'b1;
        repeat (24) send_dim(rand_dim(1'b1));
      end
      random_pairs(60, (phase % 2) == 0);
    end

    // --- saturation: max weight, max gap, squares sum past 2^56-1; the
    //     narrow counts run past MAX_DIMS and must stop at the cap ---
    configure(MODE_EUCL, '1, '1, 16'hFFFF);
    for (int k = 0; k < SAT_DIMS; k++)
      send_dim(make_dim(16'h7FFF, 16'h8000, SPREAD_W'($urandom), SPREAD_W'($urandom),
                        k == SAT_DIMS - 1));

    // --- last part: all-zero settings, no idling on either side ---
    configure(MODE_MAX, '0, '0, '0);
    quiet = 1'b1;
    random_pairs(100, 1'b0);

    drain();
    if (verdicts.mismatches == 0 && verdicts.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
